// File: rtl/spgi_pkg.sv
// ----------------------------------------------------------------------------
// spgi_pkg - shared types and constants for the polar to grid index mapper
// register map, grid and scan limits, quarter-wave sine table generator
// ----------------------------------------------------------------------------
package spgi_pkg;

  // register map of the configuration port
  typedef enum logic [2:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_RANGE_MAX   = 3'd2,
    REG_ROW_SCALE   = 3'd3,
    REG_COL_SCALE   = 3'd4,
    REG_ROW_COUNT   = 3'd5,
    REG_COL_COUNT   = 3'd6
  } cfg_reg_t;

  // scan and grid limits
  localparam int unsigned MAX_SAMPLES   = 4096;
  localparam int unsigned MAX_GRID_SIDE = 1024;
  localparam logic [16:0] SAMPLE_LIMIT  = 17'(MAX_SAMPLES);
  localparam logic [15:0] GRID_SIDE_MAX = 16'(MAX_GRID_SIDE);

  // fixed-point constants for the sine series
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  // quarter-wave sine entry k in q15, evaluated at elaboration only
  function automatic logic [15:0] quarter_sine_entry(input int unsigned k,
                                                     input int unsigned tbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (64'(k) * HALF_PI_Q30 * 64'd4) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32768) begin
      sum = 64'sd32768;
    end
    return sum[15:0];
  endfunction

endpackage

// File: rtl/scan_polar_to_grid_index_top.sv
// ----------------------------------------------------------------------------
// scan_polar_to_grid_index_top - laser scan sample to grid row and column
// beam angle, sine and cosine lookup, scaling and flooring in a six-stage pipe
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) takes one word per sample: its index in
//   the scan and its range. output channel (out_valid/out_ready) gives one word
//   per sample: floored grid row and column (saturated to 16 bits) and a flag
//   that is set when both lie inside the configured grid and the index is in
//   the scan.
//   configuration channel (cfg_valid/cfg_ready) writes one register per word;
//   cfg_ready is always high. write only while the pipe is empty.
//   an accepted word passes through every stage register in turn to the output;
//   throughput is one word per cycle while the receiver takes words, set by
//   the pipe itself: every stage registers its data and a valid bit, and
//   every stage passes its word on whenever the receiver takes words.
//   when the receiver stalls, a stage holds only if the stage after it is
//   full, so bubbles are squeezed out and input keeps flowing until every
//   stage holds a word. nothing is dropped or repeated.
//   synchronous reset empties the pipe and loads the register defaults; the
//   sine table is constant logic and needs no fill.
// ----------------------------------------------------------------------------
module scan_polar_to_grid_index_top
  import spgi_pkg::*;
#(
  parameter int unsigned TRIG_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  // sample input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        sample_index,
  input  logic [15:0]        range_sample,
  // grid index output
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] grid_row,
  output logic signed [15:0] grid_col,
  output logic               in_bounds,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int unsigned TRIG_SIZE = 1 << TRIG_TABLE_BITS;
  localparam int unsigned QUARTER   = TRIG_SIZE / 4;
  localparam int unsigned ADDR_W    = TRIG_TABLE_BITS - 1;
  localparam int unsigned NSTG      = 6;

  // configuration registers
  logic [15:0] start_angle;
  logic [15:0] angle_step;
  logic [15:0] range_max;
  logic [23:0] row_scale;
  logic [23:0] col_scale;
  logic [10:0] row_count;
  logic [10:0] col_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle <= '0;
      angle_step  <= '0;
      range_max   <= 16'd30720;
      row_scale   <= 24'd65536;
      col_scale   <= 24'd65536;
      row_count   <= 11'd1024;
      col_count   <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_ANGLE: start_angle <= cfg_data[15:0];
        REG_ANGLE_STEP:  angle_step  <= cfg_data[15:0];
        REG_RANGE_MAX:   range_max   <= cfg_data[15:0];
        REG_ROW_SCALE:   row_scale   <= cfg_data;
        REG_COL_SCALE:   col_scale   <= cfg_data;
        REG_ROW_COUNT:   row_count   <= cfg_data[10:0];
        REG_COL_COUNT:   col_count   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // quarter-wave sine table, q15, entries 0..QUARTER
  logic [15:0] sine_rom [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    localparam logic [15:0] ENTRY = quarter_sine_entry(k, TRIG_TABLE_BITS);
    assign sine_rom[k] = ENTRY;
  end

  // pipe control: a stage loads when it is empty or its word moves on
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: beam angle, modulo one turn
  logic [27:0] step_prod;
  logic [15:0] angle_s1;
  logic [15:0] rho_s1;
  logic        idx_ok_s1;

  assign step_prod = angle_step * sample_index;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      angle_s1  <= start_angle + step_prod[15:0];
      rho_s1    <= range_sample;
      idx_ok_s1 <= {5'b0, sample_index} < SAMPLE_LIMIT;
    end
  end

  // stage 2: sine and cosine from the quarter-wave table
  logic [TRIG_TABLE_BITS-1:0] tidx;
  logic [1:0]                 quad_s;
  logic [1:0]                 quad_c;
  logic [ADDR_W-1:0]          resid;
  logic [ADDR_W-1:0]          addr_s;
  logic [ADDR_W-1:0]          addr_c;
  logic [15:0]                mag_s;
  logic [15:0]                mag_c;
  logic signed [16:0]         sin_s2;
  logic signed [16:0]         cos_s2;
  logic [15:0]                rho_s2;
  logic                       idx_ok_s2;

  assign tidx   = angle_s1[15 -: TRIG_TABLE_BITS];
  assign quad_s = tidx[TRIG_TABLE_BITS-1 -: 2];
  assign quad_c = quad_s + 2'd1;   // cosine is a quarter turn ahead
  assign resid  = {1'b0, tidx[TRIG_TABLE_BITS-3:0]};
  assign addr_s = quad_s[0] ? ADDR_W'(QUARTER) - resid : resid;
  assign addr_c = quad_c[0] ? ADDR_W'(QUARTER) - resid : resid;
  assign mag_s  = sine_rom[addr_s];
  assign mag_c  = sine_rom[addr_c];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sin_s2    <= quad_s[1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
      cos_s2    <= quad_c[1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
      rho_s2    <= rho_s1;
      idx_ok_s2 <= idx_ok_s1;
    end
  end

  // stage 3: range times sine and cosine, q15
  logic signed [33:0] prod_s_s3;
  logic signed [33:0] prod_c_s3;
  logic               idx_ok_s3;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      prod_s_s3 <= $signed({1'b0, rho_s2}) * sin_s2;
      prod_c_s3 <= $signed({1'b0, rho_s2}) * cos_s2;
      idx_ok_s3 <= idx_ok_s2;
    end
  end

  // stage 4: offset by the largest range
  logic signed [33:0] offset_q15;
  logic signed [33:0] raw_row_s4;
  logic signed [33:0] raw_col_s4;
  logic               idx_ok_s4;

  assign offset_q15 = $signed({3'b0, range_max, 15'b0});

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      raw_row_s4 <= offset_q15 - prod_s_s3;
      raw_col_s4 <= offset_q15 + prod_c_s3;
      idx_ok_s4  <= idx_ok_s3;
    end
  end

  // stage 5: scale to pixels, q31 result
  logic signed [58:0] scl_row_s5;
  logic signed [58:0] scl_col_s5;
  logic               idx_ok_s5;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      scl_row_s5 <= raw_row_s4 * $signed({1'b0, row_scale});
      scl_col_s5 <= raw_col_s4 * $signed({1'b0, col_scale});
      idx_ok_s5  <= idx_ok_s4;
    end
  end

  // stage 6: floor, saturate and bounds check
  logic signed [27:0] fl_row;
  logic signed [27:0] fl_col;
  logic [15:0]        row_lim;
  logic [15:0]        col_lim;
  logic               row_in;
  logic               col_in;
  logic signed [15:0] row_sat;
  logic signed [15:0] col_sat;

  // arithmetic shift floors towards minus infinity
  assign fl_row  = scl_row_s5[58:31];
  assign fl_col  = scl_col_s5[58:31];
  assign row_lim = ({5'b0, row_count} > GRID_SIDE_MAX) ? GRID_SIDE_MAX : {5'b0, row_count};
  assign col_lim = ({5'b0, col_count} > GRID_SIDE_MAX) ? GRID_SIDE_MAX : {5'b0, col_count};
  assign row_in  = !fl_row[27] && (fl_row[26:0] < {11'b0, row_lim});
  assign col_in  = !fl_col[27] && (fl_col[26:0] < {11'b0, col_lim});

  always_comb begin
    // upper bits must all match the sign to fit in 16 bits
    if (fl_row[27:15] == {13{fl_row[27]}}) begin
      row_sat = fl_row[15:0];
    end else begin
      row_sat = fl_row[27] ? 16'sh8000 : 16'sh7FFF;
    end
    if (fl_col[27:15] == {13{fl_col[27]}}) begin
      col_sat = fl_col[15:0];
    end else begin
      col_sat = fl_col[27] ? 16'sh8000 : 16'sh7FFF;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      grid_row  <= row_sat;
      grid_col  <= col_sat;
      in_bounds <= row_in && col_in && idx_ok_s5;
    end
  end

endmodule

// File: rtl/spgi_checker.sv
// ----------------------------------------------------------------------------
// spgi_checker - port-level checks for the polar to grid index mapper
// output hold under stall, input acceptance, reset behaviour and in-bounds consistency
// ----------------------------------------------------------------------------
module spgi_checker
  import spgi_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] grid_row,
  input logic signed [15:0] grid_col,
  input logic               in_bounds
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(grid_row) &&
      $stable(grid_col) && $stable(in_bounds))
    else $error("output word changed while stalled");

  // pipe is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // a ready receiver lets the pipe take a new word
  a_ready_pass: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_ready |-> in_ready)
    else $error("input refused while output is ready");

  // in-bounds words never carry negative coordinates
  a_bounds_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_bounds |-> !grid_row[15] && !grid_col[15])
    else $error("in-bounds word with negative coordinate");

  // in-bounds words stay below the largest grid side
  a_bounds_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_bounds |->
      (grid_row < $signed(17'(MAX_GRID_SIDE))) && (grid_col < $signed(17'(MAX_GRID_SIDE))))
    else $error("in-bounds word beyond grid side");

endmodule

bind scan_polar_to_grid_index_top spgi_checker u_spgi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .grid_row  (grid_row),
  .grid_col  (grid_col),
  .in_bounds (in_bounds)
);
